// ----- hw/rtl/rv64de_pkg.sv -----
// ----------------------------------------------------------------------------
// rv64de_pkg
// Types, opcodes and helpers shared by the RV64 subset execute block.
// ----------------------------------------------------------------------------
package rv64de_pkg;

    typedef struct packed {
        logic        op;
        logic [31:0] instruction;
        logic [63:0] pc;
        logic [63:0] load_data;
    } req_t;

    typedef struct packed {
        logic [63:0] next_pc;
        logic        mem_read;
        logic        mem_write;
        logic [63:0] mem_addr;
        logic [63:0] mem_wdata;
        logic [3:0]  mem_bytes;
        logic [4:0]  wb_reg;
        logic [63:0] wb_value;
        logic        halt;
        logic [63:0] halt_code;
        logic        illegal;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MULDIV,
        ST_WB
    } state_t;

    typedef struct packed {
        logic start;
        logic div;
        logic rem;
    } md_ctrl_t;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_IMMW   = 7'h1b;
    localparam logic [6:0] OPC_REG    = 7'h33;
    localparam logic [6:0] OPC_REGW   = 7'h3b;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
    localparam logic [4:0]  HALT_REG    = 5'd10;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULD = 7'h01;

    localparam logic [2:0] F3_H   = 3'd1;
    localparam logic [2:0] F3_W   = 3'd2;
    localparam logic [2:0] F3_D   = 3'd3;
    localparam logic [2:0] F3_BU  = 3'd4;
    localparam logic [2:0] F3_HU  = 3'd5;
    localparam logic [2:0] F3_DIV = 3'd4;
    localparam logic [2:0] F3_REM = 3'd6;

    function automatic logic [63:0] sx32(input logic [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

endpackage

// ----- hw/rtl/rv64de_muldiv.sv -----
// ----------------------------------------------------------------------------
// rv64de_muldiv
// Iterative multiply (64 steps) and signed 32-bit divide/remainder
// (32 steps) around one shared 64-bit adder.
// ----------------------------------------------------------------------------
module rv64de_muldiv (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rv64de_pkg::md_ctrl_t ctrl,
    input  logic [63:0]          a,
    input  logic [63:0]          b,
    output logic                 done,
    output logic [63:0]          result
);

    logic [63:0] acc_reg,  acc_next;
    logic [63:0] opa_reg,  opa_next;
    logic [63:0] opb_reg,  opb_next;
    logic [6:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        div_reg,  div_next;
    logic        rem_reg,  rem_next;
    logic        nq_reg,   nq_next;
    logic        nr_reg,   nr_next;

    logic [63:0] add_x, add_y, sum;
    logic        add_cin, last;
    logic [31:0] abs_a, abs_b, q_fix, r_fix;

    assign abs_a = a[31] ? (32'd0 - a[31:0]) : a[31:0];
    assign abs_b = b[31] ? (32'd0 - b[31:0]) : b[31:0];

    // shared adder: accumulate for multiply, trial subtract for divide
    always_comb
    begin
        if (div_reg)
        begin
            add_x   = {31'd0, acc_reg[31:0], opb_reg[31]};
            add_y   = ~{32'd0, opa_reg[31:0]};
            add_cin = 1'b1;
        end
        else
        begin
            add_x   = acc_reg;
            add_y   = opb_reg[0] ? opa_reg : 64'd0;
            add_cin = 1'b0;
        end
        sum = add_x + add_y + {63'd0, add_cin};
    end

    assign last = div_reg ? (cnt_reg == 7'd31) : (cnt_reg == 7'd63);

    always_comb
    begin
        acc_next  = acc_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        nq_next   = nq_reg;
        nr_next   = nr_reg;
        done_next = busy_reg && last;
        if (ctrl.start)
        begin
            acc_next  = 64'd0;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
            div_next  = ctrl.div;
            rem_next  = ctrl.rem;
            nq_next   = a[31] ^ b[31];
            nr_next   = a[31];
            if (ctrl.div)
            begin
                opa_next = {32'd0, abs_b};
                opb_next = {32'd0, abs_a};
            end
            else
            begin
                opa_next = a;
                opb_next = b;
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 7'd1;
            if (last)
                busy_next = 1'b0;
            if (div_reg)
            begin
                acc_next = sum[63] ? add_x : sum;
                opb_next = {opb_reg[62:0], ~sum[63]};
            end
            else
            begin
                acc_next = sum;
                opa_next = {opa_reg[62:0], 1'b0};
                opb_next = {1'b0, opb_reg[63:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
        nr_reg  <= nr_next;
    end

    assign q_fix = nq_reg ? (32'd0 - opb_reg[31:0]) : opb_reg[31:0];
    assign r_fix = nr_reg ? (32'd0 - acc_reg[31:0]) : acc_reg[31:0];

    always_comb
    begin
        if (!div_reg)
            result = acc_reg;
        else if (rem_reg)
            result = {{32{r_fix[31]}}, r_fix};
        else
            result = {{32{q_fix[31]}}, q_fix};
    end

    assign done = done_reg;

endmodule

// ----- hw/rtl/rv64_subset_decode_execute.sv -----
// ----------------------------------------------------------------------------
// rv64_subset_decode_execute
// Multicycle execute unit for an RV64 integer subset with a 32x64 regfile.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_req carries one request: either an
// instruction word with its pc (op = 0) or the read data for the load issued
// before (op = 1). Output channel out_valid/out_ready/out_rsp returns one
// response per request: next pc, memory request, writeback, halt, illegal.
// One request executes at a time; in_ready is high only when idle.
// From accept, a request passes the execute and writeback states before
// out_valid rises as the response register is loaded. mul/mulw and
// divw/remw also pass through the iterative multiply/divide unit, which
// shares one 64-bit adder; a divide by zero skips that unit.
// A new request is taken the cycle after the response register is loaded,
// so a stalled receiver does not block the next request; only a second
// response waits in writeback until the first is taken.
// Reset clears all regfile entries through per-entry valid bits (no clearing
// pass) and clears the pending load.
// ----------------------------------------------------------------------------
module rv64_subset_decode_execute (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rv64de_pkg::req_t   in_req,
    output logic               out_valid,
    input  logic               out_ready,
    output rv64de_pkg::rsp_t   out_rsp
);

    rv64de_pkg::state_t state_reg, state_next;

    logic [63:0] rf_mem [32];
    logic [31:0] rf_valid_reg;
    logic [63:0] rd_a_reg, rd_b_reg;
    logic        va_reg, vb_reg;
    logic [4:0]  addr_a, addr_b;

    rv64de_pkg::req_t cap_reg;
    rv64de_pkg::rsp_t res_reg, res_next;
    rv64de_pkg::rsp_t out_reg;
    logic             out_valid_reg;

    logic        pend_reg,  pend_next;
    logic [4:0]  ldest_reg, ldest_next;
    logic [2:0]  lkind_reg, lkind_next;
    logic        mdw_reg,   mdw_next;

    logic [63:0] a, b;
    logic        md_go, md_done;
    rv64de_pkg::md_ctrl_t md_ctrl, md_sel;
    logic [63:0] md_result, md_val;
    logic        accept, wb_fire;

    assign accept  = in_valid && in_ready;
    assign wb_fire = (state_reg == rv64de_pkg::ST_WB) && (!out_valid_reg || out_ready);

    // register file read, registered at accept and used in the execute state
    assign addr_a = (in_req.instruction == rv64de_pkg::EBREAK_WORD) ?
                    rv64de_pkg::HALT_REG : in_req.instruction[19:15];
    assign addr_b = in_req.instruction[24:20];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_a_reg <= rf_mem[addr_a];
            rd_b_reg <= rf_mem[addr_b];
            cap_reg  <= in_req;
        end
        if (wb_fire && res_reg.wb_reg != 5'd0)
            rf_mem[res_reg.wb_reg] <= res_reg.wb_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= 32'd0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                va_reg <= rf_valid_reg[addr_a];
                vb_reg <= rf_valid_reg[addr_b];
            end
            if (wb_fire && res_reg.wb_reg != 5'd0)
                rf_valid_reg[res_reg.wb_reg] <= 1'b1;
        end
    end

    assign a = va_reg ? rd_a_reg : 64'd0;
    assign b = vb_reg ? rd_b_reg : 64'd0;

    // decode and execute
    always_comb
    begin
        logic [31:0] i;
        logic [63:0] pc, immi, imms, immb, immj, immu, val, d;
        logic [6:0]  opc, f7;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [5:0]  sh;
        logic [4:0]  s5;
        logic        ok, wr, ld, tk;

        i    = cap_reg.instruction;
        pc   = cap_reg.pc;
        d    = cap_reg.load_data;
        opc  = i[6:0];
        f3   = i[14:12];
        f7   = i[31:25];
        rd   = i[11:7];
        sh   = i[25:20];
        s5   = b[4:0];
        immi = {{52{i[31]}}, i[31:20]};
        imms = {{52{i[31]}}, i[31:25], i[11:7]};
        immb = {{51{i[31]}}, i[31], i[7], i[30:25], i[11:8], 1'b0};
        immj = {{43{i[31]}}, i[31], i[19:12], i[20], i[30:21], 1'b0};
        immu = {{32{i[31]}}, i[31:12], 12'd0};

        res_next   = '0;
        pend_next  = pend_reg;
        ldest_next = ldest_reg;
        lkind_next = lkind_reg;
        mdw_next   = mdw_reg;
        md_go      = 1'b0;
        md_sel     = '0;
        ok         = !pend_reg;
        wr         = 1'b0;
        ld         = 1'b0;
        tk         = 1'b0;
        val        = 64'd0;
        res_next.next_pc = pc + 64'd4;

        if (cap_reg.op)
        begin
            res_next.next_pc = 64'd0;
            if (pend_reg)
            begin
                case (lkind_reg)
                    rv64de_pkg::F3_H:  val = {{48{d[15]}}, d[15:0]};
                    rv64de_pkg::F3_W:  val = rv64de_pkg::sx32(d);
                    rv64de_pkg::F3_BU: val = {56'd0, d[7:0]};
                    rv64de_pkg::F3_HU: val = {48'd0, d[15:0]};
                    default:           val = d;
                endcase
                pend_next = 1'b0;
                if (ldest_reg != 5'd0)
                begin
                    res_next.wb_reg   = ldest_reg;
                    res_next.wb_value = val;
                end
            end
        end
        else
        begin
            if (ok)
            begin
                case (opc)
                    rv64de_pkg::OPC_LUI:
                    begin
                        wr  = 1'b1;
                        val = immu;
                    end
                    rv64de_pkg::OPC_AUIPC:
                    begin
                        wr  = 1'b1;
                        val = pc + immu;
                    end
                    rv64de_pkg::OPC_JAL:
                    begin
                        wr  = 1'b1;
                        val = pc + 64'd4;
                        res_next.next_pc = pc + immj;
                    end
                    rv64de_pkg::OPC_JALR:
                    begin
                        if (f3 != 3'd0)
                            ok = 1'b0;
                        wr  = 1'b1;
                        val = pc + 64'd4;
                        res_next.next_pc = (a + immi) & ~64'd1;
                    end
                    rv64de_pkg::OPC_BRANCH:
                    begin
                        case (f3)
                            3'd0:    tk = (a == b);
                            3'd1:    tk = (a != b);
                            3'd4:    tk = ($signed(a) < $signed(b));
                            3'd5:    tk = !($signed(a) < $signed(b));
                            3'd6:    tk = (a < b);
                            3'd7:    tk = (a >= b);
                            default: ok = 1'b0;
                        endcase
                        if (tk)
                            res_next.next_pc = pc + immb;
                    end
                    rv64de_pkg::OPC_LOAD:
                    begin
                        ld = 1'b1;
                        res_next.mem_read = 1'b1;
                        res_next.mem_addr = a + immi;
                        case (f3)
                            rv64de_pkg::F3_H,
                            rv64de_pkg::F3_HU: res_next.mem_bytes = 4'd2;
                            rv64de_pkg::F3_W:  res_next.mem_bytes = 4'd4;
                            rv64de_pkg::F3_D:  res_next.mem_bytes = 4'd8;
                            rv64de_pkg::F3_BU: res_next.mem_bytes = 4'd1;
                            default:           ok = 1'b0;
                        endcase
                    end
                    rv64de_pkg::OPC_STORE:
                    begin
                        res_next.mem_write = 1'b1;
                        res_next.mem_addr  = a + imms;
                        case (f3)
                            3'd0:
                            begin
                                res_next.mem_wdata = {56'd0, b[7:0]};
                                res_next.mem_bytes = 4'd1;
                            end
                            3'd1:
                            begin
                                res_next.mem_wdata = {48'd0, b[15:0]};
                                res_next.mem_bytes = 4'd2;
                            end
                            3'd2:
                            begin
                                res_next.mem_wdata = {32'd0, b[31:0]};
                                res_next.mem_bytes = 4'd4;
                            end
                            3'd3:
                            begin
                                res_next.mem_wdata = b;
                                res_next.mem_bytes = 4'd8;
                            end
                            default: ok = 1'b0;
                        endcase
                    end
                    rv64de_pkg::OPC_IMM:
                    begin
                        wr = 1'b1;
                        case (f3)
                            3'd0: val = a + immi;
                            3'd1:
                            begin
                                if (i[31:26] == 6'd0)
                                    val = a << sh;
                                else
                                    ok = 1'b0;
                            end
                            3'd3: val = {63'd0, a < immi};
                            3'd4: val = a ^ immi;
                            3'd5:
                            begin
                                if (i[31:26] == 6'd0)
                                    val = a >> sh;
                                else if (i[31:26] == 6'h10)
                                    val = $unsigned($signed(a) >>> sh);
                                else
                                    ok = 1'b0;
                            end
                            3'd7:    val = a & immi;
                            default: ok = 1'b0;
                        endcase
                    end
                    rv64de_pkg::OPC_IMMW:
                    begin
                        wr = 1'b1;
                        if (f3 == 3'd0)
                            val = rv64de_pkg::sx32(a + immi);
                        else if (f3 == 3'd1 && f7 == rv64de_pkg::F7_BASE)
                            val = rv64de_pkg::sx32(a << sh[4:0]);
                        else if (f3 == 3'd5 && f7 == rv64de_pkg::F7_BASE)
                            val = rv64de_pkg::sx32({32'd0, a[31:0] >> sh[4:0]});
                        else if (f3 == 3'd5 && f7 == rv64de_pkg::F7_ALT)
                            val = rv64de_pkg::sx32(
                                {32'd0, $unsigned($signed(a[31:0]) >>> sh[4:0])});
                        else
                            ok = 1'b0;
                    end
                    rv64de_pkg::OPC_REG:
                    begin
                        wr = 1'b1;
                        if (f7 == rv64de_pkg::F7_BASE)
                        begin
                            case (f3)
                                3'd0:    val = a + b;
                                3'd2:    val = {63'd0, $signed(a) < $signed(b)};
                                3'd3:    val = {63'd0, a < b};
                                3'd4:    val = a ^ b;
                                3'd6:    val = a | b;
                                3'd7:    val = a & b;
                                default: ok = 1'b0;
                            endcase
                        end
                        else if (f7 == rv64de_pkg::F7_ALT && f3 == 3'd0)
                            val = a - b;
                        else if (f7 == rv64de_pkg::F7_MULD && f3 == 3'd0)
                        begin
                            md_go    = 1'b1;
                            mdw_next = 1'b0;
                        end
                        else
                            ok = 1'b0;
                    end
                    rv64de_pkg::OPC_REGW:
                    begin
                        wr = 1'b1;
                        if (f7 == rv64de_pkg::F7_BASE && f3 == 3'd0)
                            val = rv64de_pkg::sx32(a + b);
                        else if (f7 == rv64de_pkg::F7_BASE && f3 == 3'd1)
                            val = rv64de_pkg::sx32(a << s5);
                        else if (f7 == rv64de_pkg::F7_BASE && f3 == 3'd5)
                            val = rv64de_pkg::sx32({32'd0, a[31:0] >> s5});
                        else if (f7 == rv64de_pkg::F7_ALT && f3 == 3'd0)
                            val = rv64de_pkg::sx32(a - b);
                        else if (f7 == rv64de_pkg::F7_ALT && f3 == 3'd5)
                            val = rv64de_pkg::sx32(
                                {32'd0, $unsigned($signed(a[31:0]) >>> s5)});
                        else if (f7 == rv64de_pkg::F7_MULD && f3 == 3'd0)
                        begin
                            md_go    = 1'b1;
                            mdw_next = 1'b1;
                        end
                        else if (f7 == rv64de_pkg::F7_MULD &&
                                 (f3 == rv64de_pkg::F3_DIV || f3 == rv64de_pkg::F3_REM))
                        begin
                            // divide by zero resolves without the divider
                            if (b[31:0] == 32'd0)
                                val = (f3 == rv64de_pkg::F3_DIV) ? '1 : rv64de_pkg::sx32(a);
                            else
                            begin
                                md_go      = 1'b1;
                                md_sel.div = 1'b1;
                                md_sel.rem = (f3 == rv64de_pkg::F3_REM);
                                mdw_next   = 1'b0;
                            end
                        end
                        else
                            ok = 1'b0;
                    end
                    rv64de_pkg::OPC_SYSTEM:
                    begin
                        if (i == rv64de_pkg::EBREAK_WORD)
                        begin
                            res_next.halt      = 1'b1;
                            res_next.halt_code = a;
                        end
                        else
                            ok = 1'b0;
                    end
                    default: ok = 1'b0;
                endcase
            end

            if (!ok)
            begin
                res_next         = '0;
                res_next.next_pc = pc;
                res_next.illegal = 1'b1;
                md_go            = 1'b0;
                mdw_next         = mdw_reg;
            end
            else
            begin
                if (ld)
                begin
                    pend_next  = 1'b1;
                    ldest_next = rd;
                    lkind_next = f3;
                end
                if (wr && rd != 5'd0)
                begin
                    res_next.wb_reg   = rd;
                    res_next.wb_value = val;
                end
            end
        end
    end

    always_comb
    begin
        md_ctrl       = md_sel;
        md_ctrl.start = (state_reg == rv64de_pkg::ST_EXEC) && md_go;
    end

    rv64de_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (md_ctrl),
        .a      (a),
        .b      (b),
        .done   (md_done),
        .result (md_result)
    );

    assign md_val = mdw_reg ? rv64de_pkg::sx32(md_result) : md_result;

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rv64de_pkg::ST_IDLE:
                if (accept)
                    state_next = rv64de_pkg::ST_EXEC;
            rv64de_pkg::ST_EXEC:
                state_next = md_go ? rv64de_pkg::ST_MULDIV : rv64de_pkg::ST_WB;
            rv64de_pkg::ST_MULDIV:
                if (md_done)
                    state_next = rv64de_pkg::ST_WB;
            rv64de_pkg::ST_WB:
                if (wb_fire)
                    state_next = rv64de_pkg::ST_IDLE;
            default:
                state_next = rv64de_pkg::ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        in_ready = (state_reg == rv64de_pkg::ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rv64de_pkg::ST_IDLE;
            pend_reg      <= 1'b0;
            ldest_reg     <= 5'd0;
            lkind_reg     <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rv64de_pkg::ST_EXEC)
            begin
                pend_reg  <= pend_next;
                ldest_reg <= ldest_next;
                lkind_reg <= lkind_next;
            end
            if (wb_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rv64de_pkg::ST_EXEC)
        begin
            res_reg <= res_next;
            mdw_reg <= mdw_next;
        end
        else if (state_reg == rv64de_pkg::ST_MULDIV && md_done && res_reg.wb_reg != 5'd0)
            res_reg.wb_value <= md_val;
        if (wb_fire)
            out_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_reg;

    a_x0_never_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !rf_valid_reg[0])
        else $error("x0 marked as written");

    a_illegal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_rsp.illegal |->
            !out_rsp.mem_read && !out_rsp.mem_write && out_rsp.wb_reg == 5'd0)
        else $error("illegal response carries side effects");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_rsp))
        else $error("response dropped or changed while stalled");

    a_md_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> state_reg == rv64de_pkg::ST_MULDIV)
        else $error("multiply/divide done outside its state");

endmodule
